// ===== hw/rtl/wfs_pkg.sv =====
// wfs_pkg: shared types, codes and constants for the wall follow steering block
package wfs_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_CW       = 3'd0,
    REG_GAIN_ACW      = 3'd1,
    REG_GAIN_NEAR     = 3'd2,
    REG_GAIN_FAR      = 3'd3,
    REG_NEAR_SIDE     = 3'd4,
    REG_FAR_FRONT     = 3'd5,
    REG_CURVE_FRONT   = 3'd6,
    REG_PHOTO_LIMIT   = 3'd7
  } wfs_reg_t;

  typedef enum logic [2:0] {
    BR_EMERGENCY = 3'd0,
    BR_CURVE     = 3'd1,
    BR_TOO_FAR   = 3'd2,
    BR_TOO_NEAR  = 3'd3,
    BR_FOLLOW    = 3'd4
  } wfs_branch_t;

  typedef enum logic [1:0] {
    BUZZ_LEAVE = 2'd0,
    BUZZ_SOUND = 2'd1,
    BUZZ_STOP  = 2'd2
  } wfs_buzz_t;

  typedef struct packed {
    logic [7:0]         gain_cw;
    logic [7:0]         gain_acw;
    logic [7:0]         gain_near;
    logic [7:0]         gain_far;
    logic [12:0]        near_side;
    logic [12:0]        far_front;
    logic [12:0]        curve_front;
    logic signed [15:0] photo_limit;
  } wfs_cfg_t;

  typedef struct packed {
    wfs_branch_t        branch;
    logic [7:0]         gain;
    logic signed [15:0] operand;
  } wfs_mid_t;

  typedef struct packed {
    wfs_branch_t        branch;
    logic [9:0]         linear_speed;
    logic signed [9:0]  angular_speed;
    logic [10:0]        motor_arg_a;
    logic [10:0]        motor_arg_b;
    wfs_buzz_t          buzzer_action;
  } wfs_result_t;

  localparam logic [7:0]         RST_GAIN_CW     = 8'd200;
  localparam logic [7:0]         RST_GAIN_ACW    = 8'd100;
  localparam logic [7:0]         RST_GAIN_NEAR   = 8'd60;
  localparam logic [7:0]         RST_GAIN_FAR    = 8'd15;
  localparam logic [12:0]        RST_NEAR_SIDE   = 13'd180;
  localparam logic [12:0]        RST_FAR_FRONT   = 13'd300;
  localparam logic [12:0]        RST_CURVE_FRONT = 13'd360;
  localparam logic signed [15:0] RST_PHOTO_LIMIT = -16'sd2000;

  // floor(x / 5) = (x * RCP5) >> RCP5_SHIFT for x below 2**18
  localparam logic [15:0] RCP5       = 16'd52429;
  localparam int          RCP5_SHIFT = 18;

  localparam int                CURVE_ANG_INT = -180 * 100 / 314 * 600 / 200;
  localparam logic signed [9:0] ANG_CURVE     = 10'(CURVE_ANG_INT);
  localparam logic signed [9:0] ANG_EMERGENCY = 10'sd180;
  localparam logic signed [17:0] LIM_EDGE     = 18'sd180;
  localparam logic signed [17:0] LIM_FOLLOW   = 18'sd480;

  localparam logic [9:0]  SPEED_RUN      = 10'd600;
  localparam logic [9:0]  SPEED_HALT     = 10'd0;
  localparam logic [10:0] ARG_A_RUN      = 11'd300;
  localparam logic [10:0] ARG_A_EMERG    = 11'd2000;
  localparam logic [10:0] ARG_B_NORMAL   = 11'd1080;
  localparam logic [10:0] ARG_B_WIDE     = 11'd2040;
  localparam logic [10:0] ARG_B_NEAR     = 11'd720;

endpackage

// ===== hw/rtl/wall_follow_steering.sv =====
// wall_follow_steering: top level with sample, operand and result registers
// each sample passes through the sample, operand and result registers in order
// throughput: one sample per cycle unless stalled; each stage moves on whenever the next one is free
// stall on the result side backs up through the stages to in_stall
// reset: synchronous active low, clears stage valids and kept sonar ranges to 0
// and loads the documented reset values into the configuration registers
module wall_follow_steering (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [13:0]              in_right_front_range,
  input  logic signed [13:0]              in_right_side_range,
  input  logic signed [15:0]              in_photo_left_front,
  input  logic signed [15:0]              in_photo_right_front,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_branch_taken,
  output logic [9:0]                      out_linear_speed,
  output logic signed [9:0]               out_angular_speed,
  output logic [10:0]                     out_motor_arg_a,
  output logic [10:0]                     out_motor_arg_b,
  output logic [1:0]                      out_buzzer_action
);

  wfs_pkg::wfs_cfg_t    cfg_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s2_valid_r, s2_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [12:0]          rf_r, rf_nxt;
  logic [12:0]          rs_r, rs_nxt;
  logic signed [15:0]   pl_r;
  logic signed [15:0]   pr_r;
  wfs_pkg::wfs_mid_t    mid_nxt, mid_r;
  wfs_pkg::wfs_result_t res_nxt, res_r;
  logic                 in_xfer;
  logic                 out_free, s2_free, s1_free;
  logic                 s1_move, s2_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_cw     <= wfs_pkg::RST_GAIN_CW;
      cfg_r.gain_acw    <= wfs_pkg::RST_GAIN_ACW;
      cfg_r.gain_near   <= wfs_pkg::RST_GAIN_NEAR;
      cfg_r.gain_far    <= wfs_pkg::RST_GAIN_FAR;
      cfg_r.near_side   <= wfs_pkg::RST_NEAR_SIDE;
      cfg_r.far_front   <= wfs_pkg::RST_FAR_FRONT;
      cfg_r.curve_front <= wfs_pkg::RST_CURVE_FRONT;
      cfg_r.photo_limit <= wfs_pkg::RST_PHOTO_LIMIT;
    end else if (cfg_wr_en) begin
      case (wfs_pkg::wfs_reg_t'(cfg_index))
        wfs_pkg::REG_GAIN_CW:     cfg_r.gain_cw     <= cfg_wdata[7:0];
        wfs_pkg::REG_GAIN_ACW:    cfg_r.gain_acw    <= cfg_wdata[7:0];
        wfs_pkg::REG_GAIN_NEAR:   cfg_r.gain_near   <= cfg_wdata[7:0];
        wfs_pkg::REG_GAIN_FAR:    cfg_r.gain_far    <= cfg_wdata[7:0];
        wfs_pkg::REG_NEAR_SIDE:   cfg_r.near_side   <= cfg_wdata[12:0];
        wfs_pkg::REG_FAR_FRONT:   cfg_r.far_front   <= cfg_wdata[12:0];
        wfs_pkg::REG_CURVE_FRONT: cfg_r.curve_front <= cfg_wdata[12:0];
        wfs_pkg::REG_PHOTO_LIMIT: cfg_r.photo_limit <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s2_move  = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_move  = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_xfer  = in_valid && !in_stall;

  // missing echo falls back to the kept range
  assign rf_nxt = in_right_front_range[13] ? rf_r : in_right_front_range[12:0];
  assign rs_nxt = in_right_side_range[13]  ? rs_r : in_right_side_range[12:0];

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  assign s2_valid_nxt  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_r);
  assign out_valid_nxt = s2_move ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rf_r        <= 13'd0;
      rs_r        <= 13'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        rf_r <= rf_nxt;
        rs_r <= rs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pl_r <= in_photo_left_front;
      pr_r <= in_photo_right_front;
    end
    if (s1_move) begin
      mid_r <= mid_nxt;
    end
    if (s2_move) begin
      res_r <= res_nxt;
    end
  end

  wfs_prep u_prep (
    .cfg     (cfg_r),
    .rf      (rf_r),
    .rs      (rs_r),
    .photo_l (pl_r),
    .photo_r (pr_r),
    .mid     (mid_nxt)
  );

  wfs_law u_law (
    .mid (mid_r),
    .res (res_nxt)
  );

  assign out_valid         = out_valid_r;
  assign out_branch_taken  = res_r.branch;
  assign out_linear_speed  = res_r.linear_speed;
  assign out_angular_speed = res_r.angular_speed;
  assign out_motor_arg_a   = res_r.motor_arg_a;
  assign out_motor_arg_b   = res_r.motor_arg_b;
  assign out_buzzer_action = res_r.buzzer_action;

  a_kept_front: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_right_front_range[13]) |=> (rf_r == $past(in_right_front_range[12:0])))
    else $error("kept right-front range not updated on transfer");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> s1_valid_r)
    else $error("sample stage dropped while blocked");

  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_angular_speed <= 10'sd480) && (out_angular_speed >= -10'sd480)))
    else $error("angular speed out of range");

  a_halt_emerg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_linear_speed == wfs_pkg::SPEED_HALT))
      |-> (res_r.branch == wfs_pkg::BR_EMERGENCY))
    else $error("halt outside emergency");

endmodule

// ===== hw/rtl/wfs_prep.sv =====
// wfs_prep: branch selection and gain operand preparation
module wfs_prep (
  input  wfs_pkg::wfs_cfg_t   cfg,
  input  logic [12:0]         rf,
  input  logic [12:0]         rs,
  input  logic signed [15:0]  photo_l,
  input  logic signed [15:0]  photo_r,
  output wfs_pkg::wfs_mid_t   mid
);

  logic        emerg;
  logic [15:0] rs6;
  logic [31:0] rcp_prod;
  logic [13:0] rs_scaled;
  logic [15:0] far_diff;
  logic [15:0] near_sum;
  logic [15:0] follow_diff;

  assign emerg = (photo_l < cfg.photo_limit) || (photo_r < cfg.photo_limit);

  // rs * 12 / 10 taken as rs * 6 / 5
  assign rs6       = {1'b0, rs, 2'b00} + {2'b00, rs, 1'b0};
  assign rcp_prod  = 32'(rs6) * 32'(wfs_pkg::RCP5);
  assign rs_scaled = rcp_prod[wfs_pkg::RCP5_SHIFT +: 14];

  assign far_diff    = {3'b000, rf} - {3'b000, cfg.far_front};
  assign near_sum    = {3'b000, rs} + {3'b000, rf} - {2'b00, cfg.near_side, 1'b0};
  assign follow_diff = {3'b000, rf} - {2'b00, rs_scaled};

  always_comb begin
    mid.branch  = wfs_pkg::BR_FOLLOW;
    mid.gain    = 8'd0;
    mid.operand = 16'sd0;
    if (emerg) begin
      mid.branch = wfs_pkg::BR_EMERGENCY;
    end else if (rf > cfg.curve_front) begin
      mid.branch = wfs_pkg::BR_CURVE;
    end else if (rf > cfg.far_front) begin
      mid.branch  = wfs_pkg::BR_TOO_FAR;
      mid.gain    = cfg.gain_far;
      mid.operand = $signed(far_diff);
    end else if (rs < cfg.near_side) begin
      mid.branch  = wfs_pkg::BR_TOO_NEAR;
      mid.gain    = cfg.gain_near;
      mid.operand = $signed(near_sum);
    end else begin
      mid.branch  = wfs_pkg::BR_FOLLOW;
      mid.gain    = follow_diff[15] ? cfg.gain_cw : cfg.gain_acw;
      mid.operand = $signed(follow_diff);
    end
  end

endmodule

// ===== hw/rtl/wfs_law.sv =====
// wfs_law: gain product, truncating scale, clamp and result field encoding
module wfs_law (
  input  wfs_pkg::wfs_mid_t    mid,
  output wfs_pkg::wfs_result_t res
);

  logic signed [24:0] prod;
  logic signed [24:0] neg_prod;
  logic signed [17:0] quot;
  logic signed [17:0] lim;
  logic signed [17:0] clamped;

  assign prod     = $signed({1'b0, mid.gain}) * mid.operand;
  assign neg_prod = -prod;
  // divide by 128 rounding toward zero
  assign quot     = neg_prod[24] ? 18'((neg_prod + 25'sd127) >>> 7) : 18'(neg_prod >>> 7);
  assign lim      = (mid.branch == wfs_pkg::BR_FOLLOW) ? wfs_pkg::LIM_FOLLOW
                                                       : wfs_pkg::LIM_EDGE;

  always_comb begin
    if (quot > lim) begin
      clamped = lim;
    end else if (quot < -lim) begin
      clamped = -lim;
    end else begin
      clamped = quot;
    end
  end

  always_comb begin
    res.branch        = mid.branch;
    res.linear_speed  = wfs_pkg::SPEED_RUN;
    res.angular_speed = clamped[9:0];
    res.motor_arg_a   = wfs_pkg::ARG_A_RUN;
    res.motor_arg_b   = wfs_pkg::ARG_B_NORMAL;
    res.buzzer_action = wfs_pkg::BUZZ_LEAVE;
    case (mid.branch)
      wfs_pkg::BR_EMERGENCY: begin
        res.linear_speed  = wfs_pkg::SPEED_HALT;
        res.angular_speed = wfs_pkg::ANG_EMERGENCY;
        res.motor_arg_a   = wfs_pkg::ARG_A_EMERG;
      end
      wfs_pkg::BR_CURVE: begin
        res.angular_speed = wfs_pkg::ANG_CURVE;
        res.motor_arg_b   = wfs_pkg::ARG_B_WIDE;
      end
      wfs_pkg::BR_TOO_FAR: begin
        res.motor_arg_b   = wfs_pkg::ARG_B_WIDE;
      end
      wfs_pkg::BR_TOO_NEAR: begin
        res.motor_arg_b   = wfs_pkg::ARG_B_NEAR;
        res.buzzer_action = wfs_pkg::BUZZ_SOUND;
      end
      wfs_pkg::BR_FOLLOW: begin
        res.buzzer_action = wfs_pkg::BUZZ_STOP;
      end
      default: begin
        res.buzzer_action = wfs_pkg::BUZZ_LEAVE;
      end
    endcase
  end

endmodule

// ===== tb/tb_wall_follow_steering.sv =====
// tb_wall_follow_steering: self-checking testbench for the wall follow steering block
module tb_wall_follow_steering;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES     = 9;
  localparam int PER_PHASE  = 170;
  localparam int CURVE_TURN = -180 * 100 / 314 * 600 / 200;

  typedef struct packed {
    logic signed [13:0]   front;
    logic signed [13:0]   side;
    logic signed [15:0]   photo_l;
    logic signed [15:0]   photo_r;
    logic                 typed;
    wfs_pkg::wfs_result_t want;
  } probe_t;

  localparam wfs_pkg::wfs_result_t R_EMERG  = '{wfs_pkg::BR_EMERGENCY, 10'd0, 10'sd180,
                                                11'd2000, 11'd1080, wfs_pkg::BUZZ_LEAVE};
  localparam wfs_pkg::wfs_result_t R_CURVE  = '{wfs_pkg::BR_CURVE, 10'd600, -10'sd171,
                                                11'd300, 11'd2040, wfs_pkg::BUZZ_LEAVE};
  localparam wfs_pkg::wfs_result_t R_FOLLOW = '{wfs_pkg::BR_FOLLOW, 10'd600, 10'sd480,
                                                11'd300, 11'd1080, wfs_pkg::BUZZ_STOP};
  localparam wfs_pkg::wfs_result_t R_NONE   = '0;

  localparam int NPROBES = 20;
  localparam probe_t PROBES [0:NPROBES-1] = '{
    '{-14'sd1,   -14'sd1,   16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd100,  14'sd200,  -16'sd2001,  16'sd0,      1'b1, R_EMERG},
    '{14'sd100,  14'sd200,  16'sd32767,  16'h8000,    1'b1, R_EMERG},
    '{14'sd8191, 14'sd8191, -16'sd2000,  -16'sd2000,  1'b1, R_CURVE},
    '{14'h2000,  -14'sd1,   16'sd32767,  16'sd32767,  1'b1, R_CURVE},
    '{14'sd361,  14'sd100,  16'sd0,      16'sd0,      1'b1, R_CURVE},
    '{14'sd360,  14'sd100,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd301,  14'sd100,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd300,  14'sd179,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd300,  14'sd180,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd0,    14'sd8191, 16'sd0,      16'sd0,      1'b1, R_FOLLOW},
    '{-14'sd1,   -14'sd1,   -16'sd1,     -16'sd1,     1'b0, R_NONE},
    '{14'sd0,    14'sd0,    16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd250,  14'sd0,    16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd0,    14'h2000,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd200,  14'sd8191, 16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd290,  14'sd240,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd200,  14'sd200,  16'sd0,      16'sd0,      1'b0, R_NONE},
    '{14'sd8191, 14'sd100,  -16'sd1999,  16'h8000,    1'b1, R_EMERG},
    '{14'sd5000, 14'sd5000, 16'h8000,    16'h8000,    1'b1, R_EMERG}
  };

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [wfs_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [wfs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic signed [13:0]              in_right_front_range = '0;
  logic signed [13:0]              in_right_side_range = '0;
  logic signed [15:0]              in_photo_left_front = '0;
  logic signed [15:0]              in_photo_right_front = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [2:0]                      out_branch_taken;
  logic [9:0]                      out_linear_speed;
  logic signed [9:0]               out_angular_speed;
  logic [10:0]                     out_motor_arg_a;
  logic [10:0]                     out_motor_arg_b;
  logic [1:0]                      out_buzzer_action;

  wfs_pkg::wfs_cfg_t    steer_cfg;
  logic [12:0]          kept_front;
  logic [12:0]          kept_side;
  wfs_pkg::wfs_result_t pending_commands [$];
  int                   errors = 0;
  bit                   in_fire = 1'b0;
  logic                 row_typed = 1'b0;
  wfs_pkg::wfs_result_t row_want = '0;

  wall_follow_steering dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic wfs_pkg::wfs_result_t steer_predict(logic signed [13:0] rf_in,
                                                         logic signed [13:0] rs_in,
                                                         logic signed [15:0] pl,
                                                         logic signed [15:0] pr);
    wfs_pkg::wfs_result_t res;
    longint rf, rs, ang, dif, g;
    rf = rf_in;
    rs = rs_in;
    if (rf < 0) rf = kept_front;
    if (rs < 0) rs = kept_side;
    kept_front = 13'(rf);
    kept_side  = 13'(rs);
    res.linear_speed  = 10'd600;
    res.motor_arg_a   = 11'd300;
    res.buzzer_action = wfs_pkg::BUZZ_LEAVE;
    if (pl < steer_cfg.photo_limit || pr < steer_cfg.photo_limit) begin
      res.branch       = wfs_pkg::BR_EMERGENCY;
      res.linear_speed = 10'd0;
      ang              = 180;
      res.motor_arg_a  = 11'd2000;
      res.motor_arg_b  = 11'd1080;
    end else if (rf > longint'(steer_cfg.curve_front)) begin
      res.branch      = wfs_pkg::BR_CURVE;
      ang             = CURVE_TURN;
      res.motor_arg_b = 11'd2040;
    end else if (rf > longint'(steer_cfg.far_front)) begin
      res.branch      = wfs_pkg::BR_TOO_FAR;
      ang = (-longint'(steer_cfg.gain_far) * (rf - longint'(steer_cfg.far_front))) / 128;
      ang             = clip(ang, 180);
      res.motor_arg_b = 11'd2040;
    end else if (rs < longint'(steer_cfg.near_side)) begin
      res.branch        = wfs_pkg::BR_TOO_NEAR;
      ang = (-longint'(steer_cfg.gain_near) * (rs + rf - 2 * longint'(steer_cfg.near_side))) / 128;
      ang               = clip(ang, 180);
      res.motor_arg_b   = 11'd720;
      res.buzzer_action = wfs_pkg::BUZZ_SOUND;
    end else begin
      dif = rf - rs * 12 / 10;
      g   = (dif < 0) ? longint'(steer_cfg.gain_cw) : longint'(steer_cfg.gain_acw);
      res.branch        = wfs_pkg::BR_FOLLOW;
      ang               = clip((-g * dif) / 128, 480);
      res.motor_arg_b   = 11'd1080;
      res.buzzer_action = wfs_pkg::BUZZ_STOP;
    end
    res.angular_speed = 10'(ang);
    return res;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // transfers are decided at the falling edge, where every signal has settled
  always @(negedge clk) begin : observe
    wfs_pkg::wfs_result_t res;
    if (!rst_n) begin
      steer_cfg  = '{wfs_pkg::RST_GAIN_CW, wfs_pkg::RST_GAIN_ACW, wfs_pkg::RST_GAIN_NEAR,
                     wfs_pkg::RST_GAIN_FAR, wfs_pkg::RST_NEAR_SIDE, wfs_pkg::RST_FAR_FRONT,
                     wfs_pkg::RST_CURVE_FRONT, wfs_pkg::RST_PHOTO_LIMIT};
      kept_front = '0;
      kept_side  = '0;
      in_fire    = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (wfs_pkg::wfs_reg_t'(cfg_index))
          wfs_pkg::REG_GAIN_CW:     steer_cfg.gain_cw     = cfg_wdata[7:0];
          wfs_pkg::REG_GAIN_ACW:    steer_cfg.gain_acw    = cfg_wdata[7:0];
          wfs_pkg::REG_GAIN_NEAR:   steer_cfg.gain_near   = cfg_wdata[7:0];
          wfs_pkg::REG_GAIN_FAR:    steer_cfg.gain_far    = cfg_wdata[7:0];
          wfs_pkg::REG_NEAR_SIDE:   steer_cfg.near_side   = cfg_wdata[12:0];
          wfs_pkg::REG_FAR_FRONT:   steer_cfg.far_front   = cfg_wdata[12:0];
          wfs_pkg::REG_CURVE_FRONT: steer_cfg.curve_front = cfg_wdata[12:0];
          wfs_pkg::REG_PHOTO_LIMIT: steer_cfg.photo_limit = cfg_wdata;
          default: ;
        endcase
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        res = steer_predict(in_right_front_range, in_right_side_range, in_photo_left_front,
                            in_photo_right_front);
        if (row_typed) res = row_want;
        pending_commands.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (pending_commands.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result transfer, branch %0d", $time, out_branch_taken);
        end else begin
          res = pending_commands.pop_front();
          check_field("branch_taken", int'(res.branch), int'(out_branch_taken));
          check_field("linear_speed", int'(res.linear_speed), int'(out_linear_speed));
          check_field("angular_speed", int'($signed(res.angular_speed)), int'(out_angular_speed));
          check_field("motor_arg_a", int'(res.motor_arg_a), int'(out_motor_arg_a));
          check_field("motor_arg_b", int'(res.motor_arg_b), int'(out_motor_arg_b));
          check_field("buzzer_action", int'(res.buzzer_action), int'(out_buzzer_action));
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [13:0] pick_range(int centre);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) return -14'sd1;
    if (r < 12) return 14'($urandom_range(8192, 16383));
    if (r < 55) v = centre + int'($urandom_range(0, 60)) - 30;
    else if (r < 75) v = $urandom_range(0, 700);
    else v = $urandom_range(0, 8191);
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return 14'(v);
  endfunction

  function automatic logic signed [15:0] pick_photo();
    int r;
    int lim;
    lim = steer_cfg.photo_limit;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'($urandom());
    if (r < 10) return 16'(lim - 1);
    if (r < 14) return 16'(lim);
    return 16'(lim + int'($urandom_range(0, 32767 - lim)));
  endfunction

  initial begin : rx_pace
    int  hold;
    int  calm_left;
    bit  calm;
    hold      = 0;
    calm_left = 0;
    calm      = 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        calm      = ($urandom_range(0, 4) == 0);
        calm_left = $urandom_range(50, 300);
      end
      if (hold > 0) begin
        hold--;
      end else if (!out_stall && !calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        hold = gap_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic signed [13:0] rf, input logic signed [13:0] rs,
                             input logic signed [15:0] pl, input logic signed [15:0] pr,
                             input logic typed, input wfs_pkg::wfs_result_t want);
    in_valid             <= 1'b1;
    in_right_front_range <= rf;
    in_right_side_range  <= rs;
    in_photo_left_front  <= pl;
    in_photo_right_front <= pr;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (!in_fire) @(posedge clk);
  endtask

  initial begin : stimulus
    int                 setting [0:7];
    int                 centre;
    int                 wbits;
    wfs_pkg::wfs_reg_t  r;
    logic signed [13:0] rf;
    logic signed [13:0] rs;
    bit                 tx_calm;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBES[i])
      send_sample(PROBES[i].front, PROBES[i].side, PROBES[i].photo_l, PROBES[i].photo_r,
                  PROBES[i].typed, PROBES[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge clk);
        case (ph)
          1: setting = '{255, 255, 255, 255, 8191, 8191, 8191, -32768};
          2: setting = '{0, 0, 0, 0, 0, 0, 0, -32768};
          3: setting = '{255, 255, 255, 255, 0, 0, 8191, 32767};
          4: setting = '{0, 255, 255, 1, 180, 300, 360, 0};
          default: begin
            for (int k = 0; k < 4; k++) setting[k] = $urandom_range(0, 255);
            setting[4] = $urandom_range(50, 400);
            setting[5] = $urandom_range(100, 700);
            setting[6] = setting[5] + int'($urandom_range(0, 300));
            setting[7] = -int'($urandom_range(0, 6000));
          end
        endcase
        r = r.first();
        do begin
          case (r)
            wfs_pkg::REG_GAIN_CW, wfs_pkg::REG_GAIN_ACW,
            wfs_pkg::REG_GAIN_NEAR, wfs_pkg::REG_GAIN_FAR: wbits = 8;
            wfs_pkg::REG_PHOTO_LIMIT: wbits = 16;
            default: wbits = 13;
          endcase
          @(posedge clk);
          cfg_wr_en <= 1'b1;
          cfg_index <= r;
          // junk above the register width must be dropped
          cfg_wdata <= 16'(setting[int'(r)] | ($urandom() << wbits));
          r = r.next();
        end while (r != r.first());
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end

      for (int n = 0; n < PER_PHASE; n++) begin
        if (n % 60 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        if (!tx_calm && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          repeat (gap_len()) @(posedge clk);
        end
        case ($urandom_range(0, 2))
          0: centre = steer_cfg.curve_front;
          1: centre = steer_cfg.far_front;
          default: centre = steer_cfg.near_side;
        endcase
        rf = pick_range(centre);
        if ($urandom_range(0, 1) == 1 && rf >= 0) centre = int'(rf) * 10 / 12;
        else centre = steer_cfg.near_side;
        rs = pick_range(centre);
        send_sample(rf, rs, pick_photo(), pick_photo(), 1'b0, R_NONE);
      end
    end

    in_valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wfs_pkg.sv
hw/rtl/wfs_prep.sv
hw/rtl/wfs_law.sv
hw/rtl/wall_follow_steering.sv
tb/tb_wall_follow_steering.sv
